>>> rtl/core/lprd_pkg.sv
package lprd_pkg;

	// Default field lengths in bytes; each may be set from 1 to 8.
	localparam int DEF_NAME_LEN_BYTES = 4;
	localparam int DEF_SIZE_LEN_BYTES = 4;

	localparam int BYTE_W = 8;
	localparam int KIND_W = 2;

	// Result kind codes.
	localparam logic [KIND_W-1:0] KIND_NAME    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd2;

	// Record parse phase.
	typedef enum logic [1:0] {
		PH_NAME_LEN = 2'd0,
		PH_NAME     = 2'd1,
		PH_SIZE     = 2'd2,
		PH_PAYLOAD  = 2'd3
	} phase_t;

	// One result request from the parser to the output register.
	typedef struct packed {
		logic              valid;
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] data;
		logic              last;
	} res_t;

endpackage

>>> rtl/core/lprd_in_reg.sv
module lprd_in_reg
	import lprd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              advance,
	output logic              valid_s1,
	output logic [BYTE_W-1:0] byte_s1
);

	// The held byte blocks the input only while the next stage cannot move.
	assign in_stall = valid_s1 && !advance;

	// Valid flag of the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Byte of the input stage; loaded only when a request is taken.
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

>>> rtl/core/lprd_core.sv
module lprd_core
	import lprd_pkg::*;
#(
	parameter int NAME_LEN_BYTES = DEF_NAME_LEN_BYTES,
	parameter int SIZE_LEN_BYTES = DEF_SIZE_LEN_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [BYTE_W-1:0] byte_s1,
	output res_t              res
);

	localparam int LEN_MAX = (NAME_LEN_BYTES > SIZE_LEN_BYTES) ? NAME_LEN_BYTES
	                                                            : SIZE_LEN_BYTES;
	localparam int ASM_W   = BYTE_W * LEN_MAX;
	localparam int IDX_W   = (LEN_MAX > 1) ? $clog2(LEN_MAX) : 1;

	localparam logic [IDX_W-1:0] NAME_LAST_IDX = IDX_W'(NAME_LEN_BYTES - 1);
	localparam logic [IDX_W-1:0] SIZE_LAST_IDX = IDX_W'(SIZE_LEN_BYTES - 1);

	phase_t           phase_q, phase_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [ASM_W-1:0] asm_q, asm_d;
	logic [ASM_W-1:0] rem_q, rem_d;
	logic [ASM_W-1:0] asm_g;
	logic [IDX_W-1:0] last_idx;
	logic             field_done;
	logic             data_last;

	// State registers advance once per processed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NAME_LEN;
			idx_q   <= '0;
			asm_q   <= '0;
			rem_q   <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			asm_q   <= asm_d;
			rem_q   <= rem_d;
		end
	end

	// Merge the incoming byte into its little-endian lane of the assembly.
	always_comb begin
		asm_g = asm_q;
		for (int k = 0; k < LEN_MAX; k++) begin
			if (idx_q == IDX_W'(k)) begin
				asm_g[k*BYTE_W +: BYTE_W] = asm_q[k*BYTE_W +: BYTE_W] | byte_s1;
			end
		end
	end

	assign last_idx   = (phase_q == PH_SIZE) ? SIZE_LAST_IDX : NAME_LAST_IDX;
	assign field_done = (idx_q == last_idx);
	// A count of one or less marks the final data byte.
	assign data_last  = (rem_q[ASM_W-1:1] == '0);

	// Next state and result request.
	always_comb begin
		phase_d   = phase_q;
		idx_d     = idx_q;
		asm_d     = asm_q;
		rem_d     = rem_q;
		res.valid = 1'b0;
		res.kind  = KIND_NAME;
		res.data  = byte_s1;
		res.last  = 1'b0;
		unique case (phase_q)
			PH_NAME_LEN, PH_SIZE: begin
				if (field_done) begin
					idx_d = '0;
					asm_d = '0;
					rem_d = asm_g;
					if (phase_q == PH_NAME_LEN) begin
						// An empty name skips straight to the size field.
						phase_d = (asm_g == '0) ? PH_SIZE : PH_NAME;
					end else if (asm_g == '0) begin
						// An empty file yields a single marker.
						res.valid = 1'b1;
						res.kind  = KIND_EMPTY;
						res.data  = '0;
						res.last  = 1'b1;
						phase_d   = PH_NAME_LEN;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end else begin
					idx_d = idx_q + IDX_W'(1);
					asm_d = asm_g;
				end
			end
			PH_NAME, PH_PAYLOAD: begin
				res.valid = 1'b1;
				res.kind  = (phase_q == PH_NAME) ? KIND_NAME : KIND_PAYLOAD;
				res.last  = data_last;
				rem_d     = data_last ? '0 : rem_q - ASM_W'(1);
				if (data_last) begin
					phase_d = (phase_q == PH_NAME) ? PH_SIZE : PH_NAME_LEN;
				end
			end
			default: begin
				phase_d = PH_NAME_LEN;
			end
		endcase
	end

endmodule

>>> rtl/core/lprd_out_reg.sv
module lprd_out_reg
	import lprd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  res_t              res,
	output logic              advance,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [KIND_W-1:0] out_kind,
	output logic [BYTE_W-1:0] out_byte,
	output logic              out_last
);

	// The register may load whenever it is empty or being drained.
	assign advance = !out_valid || !out_stall;

	// Valid flag of the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1 && res.valid;
		end
	end

	// Result payload; held steady while the receiver stalls.
	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res.valid) begin
			out_kind <= res.kind;
			out_byte <= res.data;
			out_last <= res.last;
		end
	end

endmodule

>>> rtl/core/length_prefixed_record_deframer.sv
// Record deframer for an unpacked archive byte stream.
// Input channel (in_valid, in_stall, in_byte) takes one stream byte per
// request. Each record is a little-endian name length, the name bytes, a
// little-endian file size and the payload bytes. Length bytes give no
// result; each name or payload byte gives one result on the output channel
// (out_valid, out_stall, out_kind, out_byte, out_last), with out_last set on
// the final byte of the name and of the payload. A zero-size file gives one
// empty-file marker with out_last set and a zero byte.
// The input register holds each taken byte, one pass of parse logic runs,
// and the result register loads whenever it is empty or being drained.
// Throughput: one byte per cycle while the receiver does not stall; the parse
// pass is a single phase/count update with a decrement as wide as the longer
// length field, so nothing iterates.
// Reset clears the parse state to the start of a name-length field and
// empties both registers. While the receiver stalls a valid result, the
// result holds, the input register holds its byte, and in_stall rises once
// that register is occupied.
module length_prefixed_record_deframer
	import lprd_pkg::*;
#(
	parameter int NAME_LEN_BYTES = DEF_NAME_LEN_BYTES,
	parameter int SIZE_LEN_BYTES = DEF_SIZE_LEN_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] in_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [KIND_W-1:0] out_kind,
	output logic [BYTE_W-1:0] out_byte,
	output logic              out_last
);

	logic              advance;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	res_t              res;

	// Input register.
	lprd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	// Record parser.
	lprd_core #(
		.NAME_LEN_BYTES (NAME_LEN_BYTES),
		.SIZE_LEN_BYTES (SIZE_LEN_BYTES)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (valid_s1 && advance),
		.byte_s1 (byte_s1),
		.res     (res)
	);

	// Result register.
	lprd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.res       (res),
		.advance   (advance),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_kind  (out_kind),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

endmodule

>>> rtl/core/lprd_checker.sv
module lprd_checker
	import lprd_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [KIND_W-1:0] out_kind,
	input logic [BYTE_W-1:0] out_byte,
	input logic              out_last
);

	// A stalled result stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_kind) &&
			$stable(out_byte) && $stable(out_last))
		else $error("stalled result changed");

	// The input only backs up behind a stalled result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// Only the three defined kinds appear.
	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_kind == KIND_NAME || out_kind == KIND_PAYLOAD ||
			out_kind == KIND_EMPTY)
		else $error("undefined result kind");

	// The empty-file marker carries a zero byte and the last mark.
	a_empty_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_EMPTY |-> out_byte == '0 && out_last)
		else $error("malformed empty-file marker");

	// A new result needs a byte taken in the past.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid, 2) || $past(in_stall, 2) ||
			$past(out_valid, 2))
		else $error("result without a preceding request");

endmodule

bind length_prefixed_record_deframer lprd_checker u_lprd_checker (.*);

>>> tb/length_prefixed_record_deframer_tb.sv
import lprd_pkg::*;

// One expected deframer result.
typedef struct {
	logic [KIND_W-1:0] kind;
	logic [BYTE_W-1:0] data;
	logic              last;
} deframed_t;

// Tracks the record parse and holds the results still owed by the block.
class record_scoreboard;
	phase_t     phase;
	logic [2:0] byte_idx;
	logic [63:0] assembly;
	logic [63:0] remaining;
	deframed_t  expected_q[$];
	int         errors;

	function new();
		phase     = PH_NAME_LEN;
		byte_idx  = 3'd0;
		assembly  = 64'd0;
		remaining = 64'd0;
		errors    = 0;
	endfunction

	task report_mismatch(string msg);
		$display("%0t mismatch: %s", $time, msg);
		errors++;
	endtask

	function int pending();
		return expected_q.size();
	endfunction

	// Merge one length byte; returns 1 once the field is complete.
	function bit gather_length(logic [7:0] b, int field_len);
		assembly |= {56'd0, b} << (8 * byte_idx);
		if (int'(byte_idx) + 1 >= field_len) begin
			byte_idx = 3'd0;
			return 1'b1;
		end
		byte_idx = byte_idx + 3'd1;
		return 1'b0;
	endfunction

	// Queue one name or payload byte; returns 1 on the final byte.
	function bit push_data(logic [KIND_W-1:0] kind, logic [7:0] b);
		deframed_t r;
		bit fin;
		fin = (remaining <= 64'd1);
		r.kind = kind;
		r.data = b;
		r.last = fin;
		expected_q.push_back(r);
		remaining = fin ? 64'd0 : remaining - 64'd1;
		return fin;
	endfunction

	// Advance the parse by one accepted request.
	function void note_input(logic [7:0] b);
		deframed_t r;
		case (phase)
			PH_NAME_LEN: begin
				if (gather_length(b, lprd_pkg::DEF_NAME_LEN_BYTES)) begin
					remaining = assembly;
					assembly  = 64'd0;
					phase     = (remaining == 64'd0) ? PH_SIZE : PH_NAME;
				end
			end
			PH_NAME: begin
				if (push_data(KIND_NAME, b))
					phase = PH_SIZE;
			end
			PH_SIZE: begin
				if (gather_length(b, lprd_pkg::DEF_SIZE_LEN_BYTES)) begin
					remaining = assembly;
					assembly  = 64'd0;
					if (remaining == 64'd0) begin
						// An empty file gives a single marker.
						r.kind = KIND_EMPTY;
						r.data = 8'd0;
						r.last = 1'b1;
						expected_q.push_back(r);
						phase = PH_NAME_LEN;
					end else begin
						phase = PH_PAYLOAD;
					end
				end
			end
			default: begin
				if (push_data(KIND_PAYLOAD, b))
					phase = PH_NAME_LEN;
			end
		endcase
	endfunction

	// Compare one accepted result with the oldest expectation.
	task check_result(logic [KIND_W-1:0] kind, logic [7:0] data, logic last);
		deframed_t e;
		if (expected_q.size() == 0) begin
			report_mismatch($sformatf("unexpected result kind %0d byte %02h last %0d",
				kind, data, last));
			return;
		end
		e = expected_q.pop_front();
		if (kind !== e.kind)
			report_mismatch($sformatf("out_kind %0d, expected %0d", kind, e.kind));
		if (data !== e.data)
			report_mismatch($sformatf("out_byte %02h, expected %02h", data, e.data));
		if (last !== e.last)
			report_mismatch($sformatf("out_last %0d, expected %0d", last, e.last));
	endtask
endclass

module length_prefixed_record_deframer_tb;

	localparam int NAME_BYTES   = lprd_pkg::DEF_NAME_LEN_BYTES;
	localparam int SIZE_BYTES   = lprd_pkg::DEF_SIZE_LEN_BYTES;
	localparam int ITEM_TARGET  = 900;
	localparam int HOLD_CYCLES  = 300;
	localparam int IDLE_LIMIT   = 4000;
	localparam int TAIL_CYCLES  = 10;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [BYTE_W-1:0] in_byte;
	logic              out_valid;
	logic              out_stall;
	logic [KIND_W-1:0] out_kind;
	logic [BYTE_W-1:0] out_byte;
	logic              out_last;

	record_scoreboard sb;
	int  bytes_sent;
	int  hold_asked;
	bit  calm;

	length_prefixed_record_deframer #(
		.NAME_LEN_BYTES(NAME_BYTES),
		.SIZE_LEN_BYTES(SIZE_BYTES)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_kind (out_kind),
		.out_byte (out_byte),
		.out_last (out_last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Gap lengths: mostly short, now and then long.
	function automatic int pick_gap();
		if ($urandom_range(0, 15) == 0)
			return $urandom_range(20, 60);
		return $urandom_range(1, 3);
	endfunction

	// Drop valid for a number of cycles.
	task automatic idle_for(int n);
		in_valid <= 1'b0;
		in_byte  <= 8'($urandom);
		repeat (n) @(posedge clk);
	endtask

	// Offer one byte and hold it until the request is taken.
	task automatic send_byte(logic [7:0] b);
		in_valid <= 1'b1;
		in_byte  <= b;
		do @(posedge clk); while (in_stall);
		sb.note_input(b);
		bytes_sent++;
		if (!calm && $urandom_range(0, 3) == 0)
			idle_for(pick_gap());
	endtask

	// Send one record; fill below zero means random content bytes.
	task automatic send_record(longint unsigned name_len, longint unsigned size, int fill);
		for (int i = 0; i < NAME_BYTES; i++)
			send_byte(8'(name_len >> (8 * i)));
		for (longint unsigned i = 0; i < name_len; i++)
			send_byte(fill < 0 ? 8'($urandom) : 8'(fill));
		for (int i = 0; i < SIZE_BYTES; i++)
			send_byte(8'(size >> (8 * i)));
		for (longint unsigned i = 0; i < size; i++)
			send_byte(fill < 0 ? 8'($urandom) : 8'(fill));
	endtask

	// Pause the sender until every expected result has come out.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Receiver: check results and drive random stalls, with a long hold on request.
	initial begin
		int stall_left;
		int hold_left;
		int hold_done;
		stall_left = 0;
		hold_left  = 0;
		hold_done  = 0;
		out_stall  = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				sb.check_result(out_kind, out_byte, out_last);
			if (hold_asked != hold_done) begin
				hold_done = hold_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				stall_left = pick_gap() - 1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: end the run if no request moves for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("length_prefixed_record_deframer_tb: errors");
		$finish;
	end

	// Main stimulus.
	initial begin
		longint unsigned name_len;
		longint unsigned size;
		bit drained_mid;
		sb          = new();
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_byte     = 8'd0;
		calm        = 1'b1;
		bytes_sent  = 0;
		hold_asked  = 0;
		drained_mid = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty name with empty file, one-byte name and payload of all ones,
		// two-byte name of zeros with an empty file.
		send_record(0, 0, -1);
		send_record(1, 1, 8'hFF);
		send_record(2, 0, 8'h00);

		// Long receiver hold while the sender keeps offering bytes.
		calm = 1'b0;
		hold_asked++;
		send_record(20, 40, -1);

		// Random records, mostly small, a few with lengths past one byte.
		while (bytes_sent < ITEM_TARGET) begin
			calm = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 15) == 0)
				name_len = $urandom_range(256, 300);
			else
				name_len = $urandom_range(0, 12);
			if ($urandom_range(0, 7) == 0)
				size = 0;
			else if ($urandom_range(0, 19) == 0)
				size = $urandom_range(256, 320);
			else
				size = $urandom_range(1, 40);
			send_record(name_len, size, -1);
			if (!drained_mid && bytes_sent > ITEM_TARGET / 2) begin
				drained_mid = 1'b1;
				wait_drained();
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			sb.report_mismatch($sformatf("%0d expected results never came", sb.pending()));
		if (sb.errors == 0)
			$display("length_prefixed_record_deframer_tb: clean");
		else
			$display("length_prefixed_record_deframer_tb: errors");
		$finish;
	end

endmodule

>>> files.f
rtl/core/lprd_pkg.sv
rtl/core/lprd_in_reg.sv
rtl/core/lprd_core.sv
rtl/core/lprd_out_reg.sv
rtl/core/length_prefixed_record_deframer.sv
rtl/core/lprd_checker.sv
tb/length_prefixed_record_deframer_tb.sv
